[design/mbnpc_pkg.sv]
package mbnpc_pkg;

    localparam int INSN_W = 32;
    localparam int ADDR_W = 64;
    localparam int REG_W  = 64;
    localparam int FCSR_W = 32;

    localparam int S_TDATA_W = 320;
    localparam int M_TDATA_W = 64;

    localparam logic [INSN_W-1:0] ERET_WORD = 32'h4200_0018;

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_REGIMM  = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_BLEZ    = 6'd6;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_COP1    = 6'd17;
    localparam logic [5:0] OP_BEQL    = 6'd20;
    localparam logic [5:0] OP_BNEL    = 6'd21;
    localparam logic [5:0] OP_BLEZL   = 6'd22;
    localparam logic [5:0] OP_BGTZL   = 6'd23;

    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_JALR = 6'd9;

    localparam logic [4:0] RS_BC1 = 5'd8;

    typedef enum logic [2:0] {
        SEL_SEQ,
        SEL_COND,
        SEL_JUMP,
        SEL_RS,
        SEL_EPC
    } sel_t;

    typedef struct packed {
        sel_t sel;
        logic taken;
    } dec_t;

endpackage

[design/mbnpc_decode.sv]
module mbnpc_decode
    import mbnpc_pkg::*;
(
    input  logic [INSN_W-1:0]       instruction,
    input  logic signed [REG_W-1:0] rs_value,
    input  logic signed [REG_W-1:0] rt_value,
    input  logic [FCSR_W-1:0]       fp_control_status,
    output dec_t                    dec
);

    logic [5:0] opc;
    logic [4:0] rsf;
    logic [4:0] rtf;
    logic [5:0] fn;
    logic       rs_neg;
    logic       rs_zero;
    logic       rs_eq_rt;
    logic [7:0] conds;

    assign opc      = instruction[31:26];
    assign rsf      = instruction[25:21];
    assign rtf      = instruction[20:16];
    assign fn       = instruction[5:0];
    assign rs_neg   = rs_value[REG_W-1];
    assign rs_zero  = (rs_value == '0);
    assign rs_eq_rt = (rs_value == rt_value);
    // cc0 lives at bit 23, cc1..cc7 at bits 25..31
    assign conds    = {fp_control_status[31:25], fp_control_status[23]};

    always_comb begin
        dec.sel   = SEL_SEQ;
        dec.taken = 1'b0;
        if (instruction == ERET_WORD) begin
            dec.sel = SEL_EPC;
        end else begin
            case (opc)
                OP_SPECIAL: begin
                    if (fn == FN_JR || fn == FN_JALR) begin
                        dec.sel = SEL_RS;
                    end
                end
                OP_REGIMM: begin
                    // BLTZ/BGEZ, likely and linking forms
                    if (!rtf[3] && !rtf[2]) begin
                        dec.sel   = SEL_COND;
                        dec.taken = rs_neg ^ rtf[0];
                    end
                end
                OP_J, OP_JAL: begin
                    dec.sel = SEL_JUMP;
                end
                OP_BEQ, OP_BEQL: begin
                    dec.sel   = SEL_COND;
                    dec.taken = rs_eq_rt;
                end
                OP_BNE, OP_BNEL: begin
                    dec.sel   = SEL_COND;
                    dec.taken = !rs_eq_rt;
                end
                OP_BLEZ, OP_BLEZL: begin
                    dec.sel   = SEL_COND;
                    dec.taken = rs_neg || rs_zero;
                end
                OP_BGTZ, OP_BGTZL: begin
                    dec.sel   = SEL_COND;
                    dec.taken = !rs_neg && !rs_zero;
                end
                OP_COP1: begin
                    if (rsf == RS_BC1) begin
                        dec.sel   = SEL_COND;
                        dec.taken = (conds[rtf[4:2]] == rtf[0]);
                    end
                end
                default: begin
                    dec.sel = SEL_SEQ;
                end
            endcase
        end
    end

endmodule

[design/mbnpc_target.sv]
module mbnpc_target
    import mbnpc_pkg::*;
(
    input  logic [INSN_W-1:0]       instruction,
    input  logic [ADDR_W-1:0]       pc,
    input  logic signed [REG_W-1:0] rs_value,
    input  logic [ADDR_W-1:0]       exception_pc,
    input  dec_t                    dec,
    output logic [ADDR_W-1:0]       next_pc
);

    logic [ADDR_W-1:0] pc_plus4;
    logic [ADDR_W-1:0] pc_plus8;
    logic [ADDR_W-1:0] br_off;
    logic [ADDR_W-1:0] br_taken;
    logic [ADDR_W-1:0] jump_pc;

    assign pc_plus4 = pc + ADDR_W'(4);
    assign pc_plus8 = pc + ADDR_W'(8);
    // offset already includes the delay-slot +4
    assign br_off   = {{(ADDR_W-18){instruction[15]}}, instruction[15:0], 2'b00}
                      + ADDR_W'(4);
    assign br_taken = pc + br_off;
    assign jump_pc  = {pc_plus4[ADDR_W-1:28], instruction[25:0], 2'b00};

    always_comb begin
        case (dec.sel)
            SEL_COND: next_pc = dec.taken ? br_taken : pc_plus8;
            SEL_JUMP: next_pc = jump_pc;
            SEL_RS:   next_pc = rs_value;
            SEL_EPC:  next_pc = exception_pc;
            default:  next_pc = pc_plus4;
        endcase
    end

endmodule

[design/mips_branch_next_pc.sv]
// Next-pc calculator for single-step. Each input beat carries a MIPS
// instruction word, its pc, the rs/rt register values, FCSR and EPC; the
// matching output beat gives the address where execution continues: EPC for
// ERET, rs for JR/JALR, the region jump for J/JAL, pc+4+offset*4 or pc+8 for
// taken or untaken conditional branches (BEQ/BNE/BLEZ/BGTZ, REGIMM BLTZ/BGEZ
// family, BC1F/BC1T, all with likely forms), pc+4 otherwise; sums wrap at
// 64 bits. Throughput is one beat per clock while the output is not stalled;
// a beat passes one input register and then one result register, with the
// decode, the 64-bit adds and a select in between. Backpressure on
// m_tready stalls both stages; s_tready stays high while the result register
// is empty or being drained.
module mips_branch_next_pc
    import mbnpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // instruction[31:0], pc[95:32], rs_value[159:96], rt_value[223:160],
    // fp_control_status[255:224], exception_pc[319:256]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // next_pc[63:0]
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic                    in_valid_reg;
    logic                    in_valid_next;
    logic [INSN_W-1:0]       insn_reg;
    logic [ADDR_W-1:0]       pc_reg;
    logic signed [REG_W-1:0] rs_reg;
    logic signed [REG_W-1:0] rt_reg;
    logic [FCSR_W-1:0]       fcsr_reg;
    logic [ADDR_W-1:0]       epc_reg;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [ADDR_W-1:0]       next_pc_reg;

    logic                    advance;
    logic                    s_beat;
    dec_t                    dec;
    logic [ADDR_W-1:0]       next_pc;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    assign in_valid_next  = s_beat || (in_valid_reg && !advance);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            insn_reg <= s_tdata[31:0];
            pc_reg   <= s_tdata[95:32];
            rs_reg   <= s_tdata[159:96];
            rt_reg   <= s_tdata[223:160];
            fcsr_reg <= s_tdata[255:224];
            epc_reg  <= s_tdata[319:256];
        end
        if (advance && in_valid_reg) begin
            next_pc_reg <= next_pc;
        end
    end

    mbnpc_decode u_decode (
        .instruction       (insn_reg),
        .rs_value          (rs_reg),
        .rt_value          (rt_reg),
        .fp_control_status (fcsr_reg),
        .dec               (dec)
    );

    mbnpc_target u_target (
        .instruction  (insn_reg),
        .pc           (pc_reg),
        .rs_value     (rs_reg),
        .exception_pc (epc_reg),
        .dec          (dec),
        .next_pc      (next_pc)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = next_pc_reg;

endmodule

[design/mbnpc_checker.sv]
module mbnpc_checker
    import mbnpc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic s_beat;
    assign s_beat = s_tvalid && s_tready;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && s_beat) ##1 (aresetn && m_tready) |=> m_tvalid)
        else $error("result not delivered two cycles after beat");

    a_eret: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && s_beat && s_tdata[31:0] == ERET_WORD) ##1 (aresetn && m_tready)
        |=> m_tdata == $past(s_tdata[319:256], 2))
        else $error("ERET did not return EPC");

    a_nop_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && s_beat && s_tdata[31:0] == '0) ##1 (aresetn && m_tready)
        |=> m_tdata == $past(s_tdata[95:32], 2) + 64'd4)
        else $error("nop did not give pc+4");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) ##1 aresetn |-> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

endmodule

bind mips_branch_next_pc mbnpc_checker u_mbnpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/tb_top.sv]
import mbnpc_pkg::*;

class next_pc_scoreboard;

    logic [ADDR_W-1:0] pending_pc[$];
    int unsigned       errors;

    function new();
        errors = 0;
    endfunction

    function logic [ADDR_W-1:0] predict_next_pc(logic [INSN_W-1:0] insn,
                                                logic [ADDR_W-1:0] pc,
                                                logic [REG_W-1:0]  rs,
                                                logic [REG_W-1:0]  rt,
                                                logic [FCSR_W-1:0] fcsr,
                                                logic [ADDR_W-1:0] epc);
        logic [5:0]        op;
        logic [4:0]        rt_fld;
        logic [ADDR_W-1:0] seq4;
        logic [ADDR_W-1:0] seq8;
        logic [ADDR_W-1:0] target;
        logic [7:0]        conds;
        logic              rs_neg;
        logic              rs_zero;
        logic              taken;
        op      = insn[31:26];
        rt_fld  = insn[20:16];
        seq4    = pc + 64'd4;
        seq8    = pc + 64'd8;
        target  = seq4 + {{46{insn[15]}}, insn[15:0], 2'b00};
        rs_neg  = rs[REG_W-1];
        rs_zero = (rs == '0);
        taken   = 1'b0;
        if (insn == ERET_WORD) begin
            return epc;
        end
        case (op)
            OP_SPECIAL: begin
                if (insn[5:0] == FN_JR || insn[5:0] == FN_JALR) begin
                    return rs;
                end
                return seq4;
            end
            OP_REGIMM: begin
                // rt = {link, 0, 0, likely, ge} for the BLTZ/BGEZ family
                if (rt_fld[3:2] != 2'b00) begin
                    return seq4;
                end
                taken = rt_fld[0] ? !rs_neg : rs_neg;
            end
            OP_J, OP_JAL: begin
                return {seq4[63:28], insn[25:0], 2'b00};
            end
            OP_BEQ, OP_BEQL: taken = (rs == rt);
            OP_BNE, OP_BNEL: taken = (rs != rt);
            OP_BLEZ, OP_BLEZL: taken = rs_neg || rs_zero;
            OP_BGTZ, OP_BGTZL: taken = !rs_neg && !rs_zero;
            OP_COP1: begin
                if (insn[25:21] != RS_BC1) begin
                    return seq4;
                end
                conds = {fcsr[31:25], fcsr[23]};
                taken = (conds[rt_fld[4:2]] == rt_fld[0]);
            end
            default: return seq4;
        endcase
        return taken ? target : seq8;
    endfunction

    function void note_beat(logic [INSN_W-1:0] insn, logic [ADDR_W-1:0] pc,
                            logic [REG_W-1:0] rs, logic [REG_W-1:0] rt,
                            logic [FCSR_W-1:0] fcsr, logic [ADDR_W-1:0] epc);
        pending_pc.push_back(predict_next_pc(insn, pc, rs, rt, fcsr, epc));
    endfunction

    function void check_beat(logic [M_TDATA_W-1:0] got);
        logic [ADDR_W-1:0] exp_pc;
        if (pending_pc.size() == 0) begin
            errors++;
            $display("%0t: unexpected next_pc beat, expected none, actual %h", $time, got);
            return;
        end
        exp_pc = pending_pc.pop_front();
        if (got !== exp_pc) begin
            errors++;
            $display("%0t: next_pc mismatch, expected %h, actual %h", $time, exp_pc, got);
        end
    endfunction

    function int outstanding();
        return pending_pc.size();
    endfunction

endclass

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 200000;

    localparam logic [4:0] RT_BLTZ    = 5'd0;
    localparam logic [4:0] RT_BGEZ    = 5'd1;
    localparam logic [4:0] RT_BLTZAL  = 5'd16;
    localparam logic [4:0] RT_BGEZALL = 5'd19;
    localparam logic [4:0] RT_UNUSED  = 5'd12;
    localparam logic [4:0] RS_MFC1    = 5'd0;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    next_pc_scoreboard sb = new();
    int unsigned       beats_in = 0;
    int unsigned       cycles = 0;

    mips_branch_next_pc i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [4:0] bc1_rt(logic [2:0] cc, logic likely, logic on_true);
        return {cc, likely, on_true};
    endfunction

    task automatic push_beat(logic [INSN_W-1:0] insn, logic [ADDR_W-1:0] pc,
                             logic [REG_W-1:0] rs, logic [REG_W-1:0] rt,
                             logic [FCSR_W-1:0] fcsr, logic [ADDR_W-1:0] epc);
        s_tvalid <= 1'b1;
        s_tdata  <= {epc, fcsr, rt, rs, pc, insn};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sb.note_beat(insn, pc, rs, rt, fcsr, epc);
        beats_in++;
    endtask

    task automatic idle_gap(int unsigned n);
        if (n != 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic directed_beats();
        logic [63:0] pc0;
        pc0 = 64'h0000_0000_0040_1000;
        push_beat(ERET_WORD, pc0, rand64(), rand64(), $urandom(), 64'hffff_ffff_8000_0180);
        push_beat(ERET_WORD ^ 32'h1, pc0, rand64(), rand64(), $urandom(), rand64());
        push_beat({OP_SPECIAL, 5'd31, 15'd0, FN_JR}, pc0, 64'h8000_0000_0000_0003,
                  rand64(), $urandom(), rand64());
        push_beat({OP_SPECIAL, 5'd4, 5'd0, 5'd31, 5'd0, FN_JALR}, pc0, 64'h7fff_ffff_ffff_fffe,
                  rand64(), $urandom(), rand64());
        idle_gap(2);
        push_beat({OP_SPECIAL, 20'h12345, 6'h2a}, pc0, rand64(), rand64(), $urandom(), rand64());
        push_beat({OP_REGIMM, 5'd2, RT_BLTZ, 16'h8000}, 64'h10, 64'hffff_ffff_ffff_ffff,
                  rand64(), $urandom(), rand64());
        push_beat({OP_REGIMM, 5'd2, RT_BGEZ, 16'h7fff}, pc0, 64'd0, rand64(), $urandom(),
                  rand64());
        push_beat({OP_REGIMM, 5'd2, RT_BLTZAL, 16'h0010}, pc0, 64'd0, rand64(), $urandom(),
                  rand64());
        push_beat({OP_REGIMM, 5'd2, RT_BGEZALL, 16'h0010}, pc0, 64'h8000_0000_0000_0000,
                  rand64(), $urandom(), rand64());
        push_beat({OP_REGIMM, 5'd2, RT_UNUSED, 16'h0010}, pc0, rand64(), rand64(), $urandom(),
                  rand64());
        push_beat({OP_J, 26'h3ff_ffff}, 64'hffff_ffff_ffff_fffc, rand64(), rand64(), $urandom(),
                  rand64());
        push_beat({OP_JAL, 26'h0}, 64'h0000_0000_1fff_fffc, rand64(), rand64(), $urandom(),
                  rand64());
        idle_gap(1);
        push_beat({OP_BEQ, 5'd1, 5'd2, 16'h0020}, pc0, 64'h1234_5678_9abc_def0,
                  64'h1234_5678_9abc_def0, $urandom(), rand64());
        push_beat({OP_BEQ, 5'd1, 5'd2, 16'h0020}, 64'hffff_ffff_ffff_fff8, 64'd5, 64'd6,
                  $urandom(), rand64());
        push_beat({OP_BNEL, 5'd1, 5'd2, 16'hffff}, pc0, 64'd5, 64'd6, $urandom(), rand64());
        push_beat({OP_BLEZ, 5'd1, 5'd0, 16'h0100}, pc0, 64'd0, rand64(), $urandom(), rand64());
        push_beat({OP_BLEZL, 5'd1, 5'd0, 16'h0100}, pc0, 64'd1, rand64(), $urandom(), rand64());
        push_beat({OP_BGTZ, 5'd1, 5'd0, 16'h0100}, pc0, 64'h7fff_ffff_ffff_ffff, rand64(),
                  $urandom(), rand64());
        push_beat({OP_BGTZL, 5'd1, 5'd0, 16'h0100}, pc0, 64'hffff_ffff_ffff_ffff, rand64(),
                  $urandom(), rand64());
        push_beat({OP_COP1, RS_BC1, bc1_rt(3'd0, 1'b0, 1'b1), 16'h0040}, pc0, rand64(),
                  rand64(), 32'h0080_0000, rand64());
        push_beat({OP_COP1, RS_BC1, bc1_rt(3'd7, 1'b1, 1'b0), 16'h0040}, pc0, rand64(),
                  rand64(), 32'h7fff_ffff, rand64());
        push_beat({OP_COP1, RS_BC1, bc1_rt(3'd3, 1'b0, 1'b1), 16'h0040}, pc0, rand64(),
                  rand64(), 32'hf7ff_ffff, rand64());
        push_beat({OP_COP1, RS_MFC1, 5'd2, 16'h0800}, pc0, rand64(), rand64(), $urandom(),
                  rand64());
        push_beat(32'hffff_ffff, pc0, rand64(), rand64(), $urandom(), rand64());
        push_beat(32'h0, 64'hffff_ffff_ffff_ffff, rand64(), rand64(), $urandom(), rand64());
    endtask

    task automatic random_beat();
        logic [INSN_W-1:0] insn;
        logic [ADDR_W-1:0] pc;
        logic [REG_W-1:0]  rs;
        logic [REG_W-1:0]  rt;
        logic [FCSR_W-1:0] fcsr;
        logic [ADDR_W-1:0] epc;
        logic [5:0]        cmp_ops[4];
        logic [5:0]        sgn_ops[4];
        cmp_ops = '{OP_BEQ, OP_BNE, OP_BEQL, OP_BNEL};
        sgn_ops = '{OP_BLEZ, OP_BGTZ, OP_BLEZL, OP_BGTZL};
        insn = $urandom();
        pc   = rand64();
        rs   = rand64();
        rt   = rand64();
        fcsr = $urandom();
        epc  = rand64();
        case ($urandom_range(0, 3))
            0: pc = 64'hffff_ffff_ffff_ff00 | 64'($urandom_range(0, 255));
            1: pc = 64'($urandom_range(0, 1023));
            default: ;
        endcase
        case ($urandom_range(0, 4))
            0: rs = 64'd0;
            1: rs = {{48{rs[15]}}, rs[15:0]};
            default: ;
        endcase
        case ($urandom_range(0, 11))
            0: insn = ERET_WORD;
            1: begin
                insn[31:26] = OP_SPECIAL;
                if ($urandom_range(0, 2) != 0) begin
                    insn[5:0] = $urandom_range(0, 1) ? FN_JR : FN_JALR;
                end
            end
            2, 3: begin
                insn[31:26] = OP_REGIMM;
                if ($urandom_range(0, 3) != 0) begin
                    insn[19:18] = 2'b00;
                end
            end
            4: insn[31:26] = $urandom_range(0, 1) ? OP_J : OP_JAL;
            5, 6: begin
                insn[31:26] = cmp_ops[2'($urandom_range(0, 3))];
                if ($urandom_range(0, 1) != 0) begin
                    rt = rs;
                end
            end
            7, 8: insn[31:26] = sgn_ops[2'($urandom_range(0, 3))];
            9, 10: begin
                insn[31:26] = OP_COP1;
                if ($urandom_range(0, 3) != 0) begin
                    insn[25:21] = RS_BC1;
                end
            end
            default: ;
        endcase
        push_beat(insn, pc, rs, rt, fcsr, epc);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_beat(m_tdata);
        end
    end

    // result-side backpressure; one long hold-off once traffic is flowing
    initial begin : ready_pattern
        int unsigned mode;
        int unsigned span;
        int unsigned k;
        bit          held;
        held = 1'b0;
        forever begin
            if (!held && beats_in >= 300) begin
                m_tready <= 1'b0;
                repeat (200) @(posedge aclk);
                held = 1'b1;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            for (k = 0; k < span; k++) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ((k % 5) < 3);
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned left;
        int unsigned burst;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        directed_beats();

        left = 930;
        while (left != 0) begin
            burst = $urandom_range(1, 40);
            if (burst > left) begin
                burst = left;
            end
            repeat (burst) random_beat();
            left -= burst;
            if ($urandom_range(0, 3) != 0) begin
                idle_gap($urandom_range(1, 6));
            end
        end
        s_tvalid <= 1'b0;

        while (sb.outstanding() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
